FILE: design/rfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfm_pkg: shared definitions for the reciprocal frequency meter
// Widths, register map, operation codes and register reset values.
// ----------------------------------------------------------------------------
package rfm_pkg;

    // Timestamp and frequency widths
    localparam int TIME_WIDTH = 48;
    localparam int Q_WIDTH    = 32;
    localparam int GAP_WIDTH  = 24;
    localparam int TO_WIDTH   = 32;
    localparam int TPS_WIDTH  = 24;
    localparam int FRAC_BITS  = Q_WIDTH - TPS_WIDTH;

    // Limit shifter is wide enough for the timestamp and the timeout
    localparam int LIM_W = (TIME_WIDTH > TO_WIDTH) ? TIME_WIDTH : TO_WIDTH;
    // Trial remainder compare width for the divider
    localparam int DIV_W = (TIME_WIDTH > Q_WIDTH + 1) ? TIME_WIDTH : Q_WIDTH + 1;
    // Bit counter serves both the serial subtract and the divider
    localparam int CNT_MAX = (TIME_WIDTH > Q_WIDTH) ? TIME_WIDTH : Q_WIDTH;
    localparam int CNT_W   = $clog2(CNT_MAX);

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_MIN_GAP = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_TPS     = 2'd2;

    // Register reset values
    localparam logic [GAP_WIDTH-1:0] MIN_GAP_RST = GAP_WIDTH'(1000);
    localparam logic [TO_WIDTH-1:0]  TIMEOUT_RST = TO_WIDTH'(1000000);
    localparam logic [TPS_WIDTH-1:0] TPS_RST     = TPS_WIDTH'(1000000);

    // Operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

endpackage

FILE: design/reciprocal_frequency_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reciprocal_frequency_meter: edge-period capture and Q24.8 frequency readout
// Bit-serial timestamp subtract/compare followed by a restoring divider.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. Every transaction is compared
// against the last accepted edge by a bit-serial subtractor, one timestamp
// bit per cycle; an edge passes through acceptance, the serial pass over
// all 48 bits and a decision step. A poll that repeats the held value or
// reports a timeout then moves to a push step that loads its result into
// the output register; a poll after a new edge first runs the 32-step
// restoring divider (one quotient bit per cycle). The output register
// frees the result side: a new transaction is taken while a result waits,
// and a poll stalls only if the previous result has not been taken yet.
// Registers sit at byte addresses 0 (min gap), 4 (timeout), 8 (tick rate).
// ----------------------------------------------------------------------------
module reciprocal_frequency_meter
    import rfm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [TIME_WIDTH-1:0] s_timestamp,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [Q_WIDTH-1:0]    m_frequency_q8,
    output logic                  m_fresh,
    output logic                  m_timed_out,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DECIDE,
        ST_DIV,
        ST_PUSH
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic                   op_reg, op_next;
    logic                   borrow_reg, borrow_next;
    logic                   gt_reg, gt_next;
    logic                   edge_pending_reg, edge_pending_next;
    logic                   res_fresh_reg, res_fresh_next;
    logic                   res_to_reg, res_to_next;
    logic                   m_valid_reg, m_valid_next;

    // Configuration registers
    logic [GAP_WIDTH-1:0]   min_gap_reg, min_gap_next;
    logic [TO_WIDTH-1:0]    timeout_reg, timeout_next;
    logic [TPS_WIDTH-1:0]   tps_reg, tps_next;

    // Datapath and stored state
    logic [TIME_WIDTH-1:0]  ts_sr_reg, ts_sr_next;
    logic [TIME_WIDTH-1:0]  last_edge_reg, last_edge_next;
    logic [TIME_WIDTH-1:0]  diff_sr_reg, diff_sr_next;
    logic [LIM_W-1:0]       lim_sr_reg, lim_sr_next;
    logic [TIME_WIDTH-1:0]  period_reg, period_next;
    logic [Q_WIDTH-1:0]     held_reg, held_next;
    logic [Q_WIDTH-1:0]     dvd_sr_reg, dvd_sr_next;
    logic [Q_WIDTH-1:0]     rem_reg, rem_next;
    logic [Q_WIDTH-1:0]     quo_sr_reg, quo_sr_next;
    logic [Q_WIDTH-1:0]     m_freq_reg, m_freq_next;
    logic                   m_fresh_reg, m_fresh_next;
    logic                   m_to_reg, m_to_next;

    // Serial subtract signals
    logic                   a_bit, b_bit, l_bit, d_bit;
    logic                   past_limit;
    // Divider signals
    logic [Q_WIDTH:0]       trial;
    logic [DIV_W:0]         trial_sub;
    logic                   trial_ge;
    // Configuration write strobe
    logic                   cfg_wr;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_frequency_q8 = m_freq_reg;
    assign m_fresh        = m_fresh_reg;
    assign m_timed_out    = m_to_reg;
    assign pready         = 1'b1;
    assign cfg_wr         = psel & penable & pwrite;

    // One bit of the timestamp difference per cycle, LSB first
    assign a_bit = ts_sr_reg[0];
    assign b_bit = last_edge_reg[0];
    assign l_bit = lim_sr_reg[0];
    assign d_bit = a_bit ^ b_bit ^ borrow_reg;

    // Difference is non-negative and above the limit; leftover limit bits must be zero
    assign past_limit = !diff_sr_reg[TIME_WIDTH-1] && gt_reg && (lim_sr_reg == '0);

    // Restoring divider step
    assign trial     = {rem_reg, dvd_sr_reg[Q_WIDTH-1]};
    assign trial_sub = {1'b0, DIV_W'(trial)} - {1'b0, DIV_W'(period_reg)};
    assign trial_ge  = !trial_sub[DIV_W];

    // Register read mux
    always_comb begin
        unique case (paddr[3:2])
            REG_MIN_GAP: prdata = DATA_W'(min_gap_reg);
            REG_TIMEOUT: prdata = DATA_W'(timeout_reg);
            REG_TPS:     prdata = DATA_W'(tps_reg);
            default:     prdata = '0;
        endcase
    end

    // Next-state logic
    always_comb begin
        state_next        = state_reg;
        bit_cnt_next      = bit_cnt_reg;
        op_next           = op_reg;
        borrow_next       = borrow_reg;
        gt_next           = gt_reg;
        edge_pending_next = edge_pending_reg;
        res_fresh_next    = res_fresh_reg;
        res_to_next       = res_to_reg;
        m_valid_next      = m_valid_reg;
        min_gap_next      = min_gap_reg;
        timeout_next      = timeout_reg;
        tps_next          = tps_reg;
        ts_sr_next        = ts_sr_reg;
        last_edge_next    = last_edge_reg;
        diff_sr_next      = diff_sr_reg;
        lim_sr_next       = lim_sr_reg;
        period_next       = period_reg;
        held_next         = held_reg;
        dvd_sr_next       = dvd_sr_reg;
        rem_next          = rem_reg;
        quo_sr_next       = quo_sr_reg;
        m_freq_next       = m_freq_reg;
        m_fresh_next      = m_fresh_reg;
        m_to_next         = m_to_reg;

        // Apply configuration writes
        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MIN_GAP: min_gap_next = pwdata[GAP_WIDTH-1:0];
                REG_TIMEOUT: timeout_next = pwdata[TO_WIDTH-1:0];
                REG_TPS:     tps_next     = pwdata[TPS_WIDTH-1:0];
                default:     ;
            endcase
        end

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = s_operation;
                    ts_sr_next   = s_timestamp;
                    lim_sr_next  = (s_operation == OP_POLL) ? LIM_W'(timeout_reg)
                                                            : LIM_W'(min_gap_reg);
                    borrow_next  = 1'b0;
                    gt_next      = 1'b0;
                    bit_cnt_next = '0;
                    state_next   = ST_DIFF;
                end
            end
            ST_DIFF: begin
                // Rotate the operands, shift in one difference bit
                ts_sr_next     = {a_bit, ts_sr_reg[TIME_WIDTH-1:1]};
                last_edge_next = {b_bit, last_edge_reg[TIME_WIDTH-1:1]};
                lim_sr_next    = lim_sr_reg >> 1;
                diff_sr_next   = {d_bit, diff_sr_reg[TIME_WIDTH-1:1]};
                borrow_next    = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_reg);
                gt_next        = (d_bit ^ l_bit) ? d_bit : gt_reg;
                if (bit_cnt_reg == CNT_W'(TIME_WIDTH - 1)) begin
                    bit_cnt_next = '0;
                    state_next   = ST_DECIDE;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (op_reg == OP_EDGE) begin
                    // Take the edge as the new reference
                    if (past_limit) begin
                        period_next       = diff_sr_reg;
                        last_edge_next    = ts_sr_reg;
                        edge_pending_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end else if (edge_pending_reg) begin
                    edge_pending_next = 1'b0;
                    dvd_sr_next       = {tps_reg, FRAC_BITS'(0)};
                    rem_next          = '0;
                    bit_cnt_next      = '0;
                    res_fresh_next    = 1'b1;
                    res_to_next       = 1'b0;
                    state_next        = ST_DIV;
                end else if (past_limit) begin
                    quo_sr_next    = '0;
                    res_fresh_next = 1'b0;
                    res_to_next    = 1'b1;
                    state_next     = ST_PUSH;
                end else begin
                    quo_sr_next    = held_reg;
                    res_fresh_next = 1'b0;
                    res_to_next    = 1'b0;
                    state_next     = ST_PUSH;
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle
                rem_next    = trial_ge ? trial_sub[Q_WIDTH-1:0] : trial[Q_WIDTH-1:0];
                quo_sr_next = {quo_sr_reg[Q_WIDTH-2:0], trial_ge};
                dvd_sr_next = {dvd_sr_reg[Q_WIDTH-2:0], 1'b0};
                if (bit_cnt_reg == CNT_W'(Q_WIDTH - 1)) begin
                    bit_cnt_next = '0;
                    state_next   = ST_PUSH;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_PUSH: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_freq_next  = quo_sr_reg;
                    m_fresh_next = res_fresh_reg;
                    m_to_next    = res_to_reg;
                    held_next    = quo_sr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            bit_cnt_reg      <= '0;
            edge_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
            min_gap_reg      <= MIN_GAP_RST;
            timeout_reg      <= TIMEOUT_RST;
            tps_reg          <= TPS_RST;
            last_edge_reg    <= '0;
            period_reg       <= '0;
            held_reg         <= '0;
        end else begin
            state_reg        <= state_next;
            bit_cnt_reg      <= bit_cnt_next;
            edge_pending_reg <= edge_pending_next;
            m_valid_reg      <= m_valid_next;
            min_gap_reg      <= min_gap_next;
            timeout_reg      <= timeout_next;
            tps_reg          <= tps_next;
            last_edge_reg    <= last_edge_next;
            period_reg       <= period_next;
            held_reg         <= held_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        borrow_reg    <= borrow_next;
        gt_reg        <= gt_next;
        res_fresh_reg <= res_fresh_next;
        res_to_reg    <= res_to_next;
        ts_sr_reg     <= ts_sr_next;
        diff_sr_reg   <= diff_sr_next;
        lim_sr_reg    <= lim_sr_next;
        dvd_sr_reg    <= dvd_sr_next;
        rem_reg       <= rem_next;
        quo_sr_reg    <= quo_sr_next;
        m_freq_reg    <= m_freq_next;
        m_fresh_reg   <= m_fresh_next;
        m_to_reg      <= m_to_next;
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again without serial pass");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_fresh_reg && m_to_reg))
        else $error("fresh and timed_out both set");

    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_to_reg |-> m_freq_reg == '0)
        else $error("timed-out result is not zero");

    a_edge_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DECIDE && op_reg == OP_EDGE && past_limit |=> edge_pending_reg)
        else $error("accepted edge did not arm the pending flag");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIFF |-> bit_cnt_reg < CNT_W'(TIME_WIDTH))
        else $error("serial bit counter out of range");

endmodule

FILE: test/tb_reciprocal_frequency_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reciprocal_frequency_meter: self-checking bench for the frequency meter
// Streams edge and poll transactions through the input channel, predicts each
// poll reading from an in-bench model of the period capture, timeout and
// Q24.8 division, and compares every reading field by field. Register
// settings change between drained phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_reciprocal_frequency_meter;
    import rfm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 600;
    // Address slot past the register list, writes there must be dropped
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                  op;
        logic [TIME_WIDTH-1:0] ts;
    } meter_event_t;

    typedef struct packed {
        logic [Q_WIDTH-1:0] freq;
        logic               fresh;
        logic               timed_out;
    } reading_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_operation = OP_EDGE;
    logic [TIME_WIDTH-1:0] s_timestamp = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [Q_WIDTH-1:0]    m_frequency_q8;
    logic                  m_fresh;
    logic                  m_timed_out;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [ADDR_W-1:0]     paddr       = '0;
    logic [DATA_W-1:0]     pwdata      = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    // Stimulus and expectation stores
    meter_event_t pending_events[$];
    reading_t     readings_due[$];

    // Register mirror
    logic [GAP_WIDTH-1:0] gap_cfg     = MIN_GAP_RST;
    logic [TO_WIDTH-1:0]  timeout_cfg = TIMEOUT_RST;
    logic [TPS_WIDTH-1:0] tps_cfg     = TPS_RST;

    // Meter state mirror
    logic [TIME_WIDTH-1:0] ref_edge_ts  = '0;
    logic [TIME_WIDTH-1:0] period_ticks = '0;
    logic                  edge_waiting = 1'b0;
    logic [Q_WIDTH-1:0]    held_q8      = '0;

    // Signal generator time base: last edge emitted on the rhythm
    logic [TIME_WIDTH-1:0] sig_time = '0;

    int items_pushed    = 0;
    int items_accepted  = 0;
    int polls_accepted  = 0;
    int results_checked = 0;
    int fresh_seen      = 0;
    int timeouts_seen   = 0;
    int mismatches      = 0;
    int settings_used   = 1;
    int cycle_count     = 0;
    int src_gap         = 0;
    int sink_gap        = 0;
    int hold_left       = 0;
    int hold_reqs       = 0;
    int holds_done      = 0;
    bit src_idle_on     = 1'b1;
    bit sink_idle_on    = 1'b1;

    reciprocal_frequency_meter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_timestamp    (s_timestamp),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frequency_q8 (m_frequency_q8),
        .m_fresh        (m_fresh),
        .m_timed_out    (m_timed_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("reciprocal_frequency_meter test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH reading %0d %s: got %0h, expected %0h",
                 results_checked, field, got, want);
        mismatches++;
    endtask

    // Advance the meter mirror by one accepted transaction
    function automatic void predict_reading(input logic op, input logic [TIME_WIDTH-1:0] ts);
        logic [TIME_WIDTH-1:0] since;
        logic [63:0]           quot;
        reading_t              r;
        since = ts - ref_edge_ts;
        if (op == OP_EDGE) begin
            // Keep the edge only if strictly past the gap and not behind the reference
            if (!since[TIME_WIDTH-1] && since > TIME_WIDTH'(gap_cfg)) begin
                period_ticks = since;
                ref_edge_ts  = ts;
                edge_waiting = 1'b1;
            end
            return;
        end
        if (edge_waiting) begin
            if (period_ticks == '0) begin
                r.freq = '1;
            end else begin
                quot = {32'h0, tps_cfg, 8'h00} / {{(64 - TIME_WIDTH){1'b0}}, period_ticks};
                r.freq = (quot > 64'hFFFF_FFFF) ? '1 : quot[Q_WIDTH-1:0];
            end
            r.fresh      = 1'b1;
            r.timed_out  = 1'b0;
            edge_waiting = 1'b0;
        end else if (!since[TIME_WIDTH-1] && since > TIME_WIDTH'(timeout_cfg)) begin
            r.freq      = '0;
            r.fresh     = 1'b0;
            r.timed_out = 1'b1;
        end else begin
            r.freq      = held_q8;
            r.fresh     = 1'b0;
            r.timed_out = 1'b0;
        end
        held_q8 = r.freq;
        readings_due.push_back(r);
    endfunction

    // Feed queued transactions, with random gaps after acceptance
    always @(posedge aclk) begin : event_driver
        meter_event_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                nxt = pending_events.pop_front();
                s_valid     <= 1'b1;
                s_operation <= nxt.op;
                s_timestamp <= nxt.ts;
                if (src_idle_on && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 16);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side ready: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin : reading_sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (holds_done < hold_reqs) begin
            holds_done = holds_done + 1;
            hold_left  = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 5) == 0)
                sink_gap = $urandom_range(1, 16);
        end
    end

    // Predict on input acceptance, check on result acceptance
    always @(posedge aclk) begin : channel_monitor
        reading_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_reading(s_operation, s_timestamp);
                items_accepted++;
                if (s_operation == OP_POLL)
                    polls_accepted++;
            end
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("unexpected reading, frequency", m_frequency_q8, '0);
                end else begin
                    want = readings_due.pop_front();
                    if (m_frequency_q8 !== want.freq)
                        report_mismatch("frequency_q8", m_frequency_q8, want.freq);
                    if (m_fresh !== want.fresh)
                        report_mismatch("fresh", 32'(m_fresh), 32'(want.fresh));
                    if (m_timed_out !== want.timed_out)
                        report_mismatch("timed_out", 32'(m_timed_out), 32'(want.timed_out));
                    if (want.fresh)
                        fresh_seen++;
                    if (want.timed_out)
                        timeouts_seen++;
                end
                results_checked++;
            end
        end
    end

    function automatic logic [TIME_WIDTH-1:0] rand48();
        return TIME_WIDTH'({$urandom_range(0, 16'hFFFF), $urandom});
    endfunction

    function automatic logic [TIME_WIDTH-1:0] pick_period();
        case ($urandom_range(0, 3))
            0: return TIME_WIDTH'(gap_cfg) + TIME_WIDTH'($urandom_range(1, 64));
            1: return TIME_WIDTH'($urandom_range(1, 1 << 20));
            2: return TIME_WIDTH'(gap_cfg) + TIME_WIDTH'($urandom_range(1, 1 << 16));
            default: return TIME_WIDTH'($urandom | 1);
        endcase
    endfunction

    task automatic add_event(input logic op, input logic [TIME_WIDTH-1:0] ts);
        meter_event_t ev;
        ev.op = op;
        ev.ts = ts;
        pending_events.push_back(ev);
        items_pushed++;
    endtask

    // Queue a signal: a periodic edge train with polls, bounces and noise mixed in
    task automatic queue_signal(input int count);
        logic [TIME_WIDTH-1:0] period;
        int                    made;
        int                    pick;
        period = pick_period();
        made   = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // edge on the rhythm, with a little jitter
                sig_time = sig_time + period + TIME_WIDTH'($urandom_range(0, 31));
                add_event(OP_EDGE, sig_time);
                made++;
            end else if (pick < 58) begin
                // contact bounce inside the gap
                add_event(OP_EDGE, sig_time + TIME_WIDTH'($urandom_range(0, gap_cfg)));
            end else if (pick < 85) begin
                add_event(OP_POLL, sig_time + TIME_WIDTH'($urandom_range(0, 1 << 20)));
                made++;
            end else if (pick < 89) begin
                // poll right around the timeout boundary
                add_event(OP_POLL, sig_time + TIME_WIDTH'(timeout_cfg)
                                   + TIME_WIDTH'($urandom_range(0, 2)));
                made++;
            end else if (pick < 92) begin
                // stale edge from behind the reference
                add_event(OP_EDGE, sig_time - (TIME_WIDTH'({$urandom_range(0, 32767),
                                                            $urandom}) + 1));
            end else if (pick < 95) begin
                add_event(OP_POLL, rand48());
                made++;
            end else if (pick < 97) begin
                // jump far ahead, still a forward difference
                sig_time = sig_time + TIME_WIDTH'({$urandom_range(0, 16383), $urandom});
                add_event(OP_EDGE, sig_time);
                made++;
            end else begin
                period = pick_period();
            end
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_GAP: gap_cfg     = data[GAP_WIDTH-1:0];
            REG_TIMEOUT: timeout_cfg = data[TO_WIDTH-1:0];
            REG_TPS:     tps_cfg     = data[TPS_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic set_meter(input logic [31:0] gap, input logic [31:0] tmo,
                             input logic [31:0] tps);
        reg_write(REG_MIN_GAP, gap);
        reg_write(REG_TIMEOUT, tmo);
        reg_write(REG_TPS, tps);
        settings_used++;
    endtask

    // Wait until every transaction is in and every reading is out, then settle
    task automatic wait_idle();
        while (items_accepted != items_pushed || readings_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : sequencer
        int mark;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, boundaries and corner cases
        add_event(OP_POLL, '0);                         // poll with nothing seen
        add_event(OP_POLL, '1);                         // poll before reference
        add_event(OP_EDGE, TIME_WIDTH'(1000));          // exactly at the gap
        add_event(OP_EDGE, TIME_WIDTH'(1001));          // just past the gap
        add_event(OP_POLL, TIME_WIDTH'(1001));
        add_event(OP_EDGE, TIME_WIDTH'(1501));          // bounce inside the gap
        add_event(OP_EDGE, TIME_WIDTH'(996));           // edge before reference
        add_event(OP_EDGE, TIME_WIDTH'(2002));
        add_event(OP_EDGE, TIME_WIDTH'(3100));          // another accepted edge, latest wins
        add_event(OP_POLL, TIME_WIDTH'(3100));
        add_event(OP_POLL, TIME_WIDTH'(1003100));       // exactly at the timeout
        add_event(OP_POLL, TIME_WIDTH'(1003101));       // one past the timeout
        add_event(OP_POLL, TIME_WIDTH'(1003101));
        add_event(OP_EDGE, {1'b1, 47'd3099});           // largest forward period
        add_event(OP_POLL, {1'b1, 47'd3100});
        add_event(OP_EDGE, '1);                         // top of the time range
        add_event(OP_EDGE, TIME_WIDTH'(1500));          // across the wrap
        add_event(OP_POLL, TIME_WIDTH'(1600));
        add_event(OP_POLL, TIME_WIDTH'(1700));          // held value repeats
        sig_time = TIME_WIDTH'(1500);
        wait_idle();

        // Extremes: no gap, a one-tick timeout, fastest tick rate
        set_meter(32'hFF00_0000, 32'd1, 32'h00FF_FFFF);
        reg_write(REG_SPARE, 32'hFFFF_FFFF);
        sig_time = sig_time + 1;
        add_event(OP_EDGE, sig_time);                   // period of one tick
        add_event(OP_POLL, sig_time);
        add_event(OP_POLL, sig_time + 2);
        queue_signal(170);
        wait_idle();

        // Opposite extremes, with a quiet receiver
        sink_idle_on = 1'b0;
        set_meter(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'd1);
        queue_signal(170);
        wait_idle();

        // Zero tick rate
        sink_idle_on = 1'b1;
        set_meter($urandom_range(0, 5000), $urandom_range(1, 1 << 24), 32'd0);
        queue_signal(130);
        wait_idle();

        // Receiver holds off while the sender keeps offering
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_meter($urandom_range(0, 1 << 16), $urandom_range(1, 1 << 22),
                  $urandom_range(1, 24'hFFFFFF));
        mark = items_accepted;
        queue_signal(130);
        while (items_accepted < mark + 4)
            @(posedge aclk);
        hold_reqs = hold_reqs + 1;
        wait_idle();

        // Random settings, sender pauses halfway until all readings are back
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        set_meter($urandom_range(0, 24'hFFFFFF), $urandom,
                  $urandom_range(1, 24'hFFFFFF));
        queue_signal(90);
        wait_idle();
        hold_reqs = hold_reqs + 1;
        queue_signal(90);
        wait_idle();

        // Closing stretch at full rate
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_meter($urandom_range(0, 1 << 12), $urandom_range(1, 1 << 24),
                  $urandom_range(1, 24'hFFFFFF));
        queue_signal(130);
        wait_idle();

        $display("Ran %0d transactions (%0d polls) across %0d register settings",
                 items_accepted, polls_accepted, settings_used);
        $display("Compared %0d readings: %0d fresh, %0d timed out, %0d mismatches",
                 results_checked, fresh_seen, timeouts_seen, mismatches);
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("reciprocal_frequency_meter test passed");
        end else begin
            $display("reciprocal_frequency_meter test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/rfm_pkg.sv
design/reciprocal_frequency_meter.sv
test/tb_reciprocal_frequency_meter.sv
